@@ sv/iwr_pkg.sv @@
// Package for the increasing word rank block: field widths, limits and the
// binomial and offset tables used by the rank sequencer.
// No dependencies.
package iwr_pkg;

  localparam int MAX_LETTERS = 5;
  localparam int LEN_W       = 3;
  localparam int LETTER_W    = 5;
  localparam int RANK_W      = 17;
  localparam int PLACE_W     = 3;

  localparam logic [LETTER_W-1:0] ALPHABET    = 5'd26;
  localparam logic [LETTER_W-1:0] LAST_LETTER = 5'd25;

  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [LEN_W-1:0]    len_t;
  typedef logic [RANK_W-1:0]   rank_t;
  typedef logic [PLACE_W-1:0]  place_t;

  // C(n,2), C(n,3), C(n,4) for n = 0 .. 25
  localparam rank_t CHOOSE2 [26] = '{
    17'd0, 17'd0, 17'd1, 17'd3, 17'd6, 17'd10, 17'd15, 17'd21, 17'd28, 17'd36,
    17'd45, 17'd55, 17'd66, 17'd78, 17'd91, 17'd105, 17'd120, 17'd136, 17'd153,
    17'd171, 17'd190, 17'd210, 17'd231, 17'd253, 17'd276, 17'd300};

  localparam rank_t CHOOSE3 [26] = '{
    17'd0, 17'd0, 17'd0, 17'd1, 17'd4, 17'd10, 17'd20, 17'd35, 17'd56, 17'd84,
    17'd120, 17'd165, 17'd220, 17'd286, 17'd364, 17'd455, 17'd560, 17'd680,
    17'd816, 17'd969, 17'd1140, 17'd1330, 17'd1540, 17'd1771, 17'd2024, 17'd2300};

  localparam rank_t CHOOSE4 [26] = '{
    17'd0, 17'd0, 17'd0, 17'd0, 17'd1, 17'd5, 17'd15, 17'd35, 17'd70, 17'd126,
    17'd210, 17'd330, 17'd495, 17'd715, 17'd1001, 17'd1365, 17'd1820, 17'd2380,
    17'd3060, 17'd3876, 17'd4845, 17'd5985, 17'd7315, 17'd8855, 17'd10626,
    17'd12650};

  // Binomial coefficient C(n,k) for n up to 25 and k up to 4
  function automatic rank_t choose(input letter_t n, input len_t k);
    rank_t r;
    r = '0;
    if (n <= LAST_LETTER) begin
      case (k)
        3'd0:    r = rank_t'(1);
        3'd1:    r = rank_t'(n);
        3'd2:    r = CHOOSE2[n];
        3'd3:    r = CHOOSE3[n];
        3'd4:    r = CHOOSE4[n];
        default: r = '0;
      endcase
    end
    return r;
  endfunction

  // Number of increasing words shorter than the given length, plus one
  function automatic rank_t shorter_count(input len_t len);
    rank_t r;
    case (len)
      3'd1:    r = 17'd0;
      3'd2:    r = 17'd26;
      3'd3:    r = 17'd351;
      3'd4:    r = 17'd2951;
      3'd5:    r = 17'd17901;
      default: r = 17'd0;
    endcase
    // 1-based rank
    return r + rank_t'(1);
  endfunction

endpackage

@@ sv/increasing_word_rank.sv @@
// Increasing word rank: one shared adder and binomial table under a small
// sequencer that walks every skipped letter of every place.
// An increasing word is ranked in the RUN state; a word that is not increasing,
// has a letter outside the alphabet or has a bad length goes straight to DONE
// with rank zero. One word at a time: the next is taken the cycle after the
// result is transferred.
// Reset (rst, synchronous) returns the sequencer to idle and drops out_valid.
module increasing_word_rank (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [iwr_pkg::LEN_W-1:0]     word_length,
  input  logic [iwr_pkg::LETTER_W-1:0]  letter_first,
  input  logic [iwr_pkg::LETTER_W-1:0]  letter_second,
  input  logic [iwr_pkg::LETTER_W-1:0]  letter_third,
  input  logic [iwr_pkg::LETTER_W-1:0]  letter_fourth,
  input  logic [iwr_pkg::LETTER_W-1:0]  letter_fifth,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [iwr_pkg::RANK_W-1:0]    word_rank
);

  typedef enum logic [1:0] {IDLE, RUN, DONE} state_t;

  state_t                state;
  iwr_pkg::letter_t      letters [iwr_pkg::MAX_LETTERS];
  iwr_pkg::len_t         len;
  iwr_pkg::place_t       place;
  iwr_pkg::letter_t      x;
  iwr_pkg::rank_t        rank;

  iwr_pkg::letter_t      in_letters [iwr_pkg::MAX_LETTERS];
  logic                  word_ok;
  iwr_pkg::letter_t      cur;
  iwr_pkg::len_t         rest;
  iwr_pkg::rank_t        term;

  assign in_letters[0] = letter_first;
  assign in_letters[1] = letter_second;
  assign in_letters[2] = letter_third;
  assign in_letters[3] = letter_fourth;
  assign in_letters[4] = letter_fifth;

  // Length in range, used letters in the alphabet and strictly increasing
  always_comb begin
    word_ok = (word_length != '0) &&
              (word_length <= iwr_pkg::len_t'(iwr_pkg::MAX_LETTERS));
    for (int i = 0; i < iwr_pkg::MAX_LETTERS; i++) begin
      if ((iwr_pkg::len_t'(i) < word_length) && (in_letters[i] >= iwr_pkg::ALPHABET))
        word_ok = 1'b0;
      if (i + 1 < iwr_pkg::MAX_LETTERS) begin
        if ((iwr_pkg::len_t'(i + 1) < word_length) &&
            (in_letters[i] >= in_letters[i + 1]))
          word_ok = 1'b0;
      end
    end
  end

  assign cur  = letters[place];
  assign rest = len - 3'd1 - iwr_pkg::len_t'(place);
  assign term = iwr_pkg::choose(iwr_pkg::LAST_LETTER - x, rest);

  assign in_stall  = (state != IDLE);
  assign out_valid = (state == DONE);
  assign word_rank = rank;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      case (state)
        IDLE: begin
          if (in_valid) begin
            letters <= in_letters;
            len     <= word_length;
            place   <= '0;
            x       <= '0;
            if (word_ok) begin
              rank  <= iwr_pkg::shorter_count(word_length);
              state <= RUN;
            end else begin
              rank  <= '0;
              state <= DONE;
            end
          end
        end
        RUN: begin
          if (x < cur) begin
            // add the words that continue from a skipped letter
            rank <= rank + term;
            x    <= x + 5'd1;
          end else if (iwr_pkg::len_t'(place) == len - 3'd1) begin
            state <= DONE;
          end else begin
            place <= place + 3'd1;
            x     <= cur + 5'd1;
          end
        end
        DONE: begin
          if (!out_stall)
            state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

@@ sv/iwr_checker.sv @@
// Port-level checks for the increasing word rank block, bound into increasing_word_rank.
// Depends on iwr_pkg for field widths.
module iwr_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [iwr_pkg::LEN_W-1:0]     word_length,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [iwr_pkg::RANK_W-1:0]    word_rank
);

  // Ready for a word only while no result is pending
  a_idle_no_result: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !out_valid)
    else $error("result shown while accepting input");

  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken without going busy");

  a_bad_length: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && word_length == '0) |=> (out_valid && word_rank == '0))
    else $error("zero length word not ranked zero at once");

  a_hold_rank: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(word_rank)))
    else $error("stalled result changed");

endmodule

bind increasing_word_rank iwr_checker u_iwr_checker (.*);

@@ bench/iwr_rank_checker.sv @@
`timescale 1ns / 1ps
// Rank checker for increasing_word_rank: watches both transfer channels,
// predicts the rank of every accepted word and compares the returned ranks.
// Depends on iwr_pkg for widths and limits.
module iwr_rank_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [iwr_pkg::LEN_W-1:0]    word_length,
  input  logic [iwr_pkg::LETTER_W-1:0] letter_first,
  input  logic [iwr_pkg::LETTER_W-1:0] letter_second,
  input  logic [iwr_pkg::LETTER_W-1:0] letter_third,
  input  logic [iwr_pkg::LETTER_W-1:0] letter_fourth,
  input  logic [iwr_pkg::LETTER_W-1:0] letter_fifth,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [iwr_pkg::RANK_W-1:0]   word_rank,
  input  logic                         drained,
  output int                           pending,
  output int                           fail_total,
  output int                           checked,
  output int                           zero_ranks
);

  typedef logic [iwr_pkg::MAX_LETTERS-1:0][iwr_pkg::LETTER_W-1:0] word_t;

  typedef struct {
    iwr_pkg::len_t  len;
    word_t          letters;
    iwr_pkg::rank_t rank;
  } rank_entry_t;

  rank_entry_t rank_q[$];
  int          n_fail    = 0;
  int          n_checked = 0;
  int          n_zero    = 0;
  bit          leftovers_done = 1'b0;

  assign fail_total = n_fail;
  assign checked    = n_checked;
  assign zero_ranks = n_zero;

  initial pending = 0;

  function automatic int unsigned binom(input int unsigned n, input int unsigned k);
    int unsigned r;
    int unsigned j;
    r = 1;
    for (j = 0; j < k; j++) begin
      if (n < j + 1) return 0;
      r = r * (n - j) / (j + 1);
    end
    return r;
  endfunction

  function automatic iwr_pkg::rank_t expected_rank(input iwr_pkg::len_t len, input word_t w);
    int unsigned total;
    int unsigned lowest;
    int unsigned p;
    int unsigned x;
    if (len == 0 || len > iwr_pkg::MAX_LETTERS) return '0;
    for (p = 0; p < len; p++)
      if (w[p] >= iwr_pkg::ALPHABET) return '0;
    for (p = 0; p + 1 < len; p++)
      if (w[p] >= w[p+1]) return '0;
    // every shorter word comes first; ranks start at one
    total = 1;
    for (p = 1; p < len; p++)
      total += binom(iwr_pkg::ALPHABET, p);
    // each letter skipped at a place stands for every word continuing from it
    lowest = 0;
    for (p = 0; p < len; p++) begin
      for (x = lowest; x < w[p]; x++)
        total += binom(iwr_pkg::ALPHABET - 1 - x, len - 1 - p);
      lowest = w[p] + 1;
    end
    return iwr_pkg::rank_t'(total);
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] rank check: %s", $time, what);
    n_fail++;
  endtask

  always @(posedge clk) begin : watch
    rank_entry_t want;
    word_t       seen;
    if (!rst) begin
      // retire first: a result never belongs to a word taken at the same edge
      if (out_valid && !out_stall) begin
        if (rank_q.size() == 0) begin
          report_mismatch($sformatf("rank %0d returned with no word outstanding",
                                    word_rank));
        end else begin
          want = rank_q.pop_front();
          n_checked++;
          if (want.rank == 0) n_zero++;
          if (word_rank !== want.rank)
            report_mismatch($sformatf("len %0d letters %0d %0d %0d %0d %0d: rank %0d, want %0d",
                                      want.len, want.letters[0], want.letters[1],
                                      want.letters[2], want.letters[3], want.letters[4],
                                      word_rank, want.rank));
        end
      end
      if (in_valid && !in_stall) begin
        seen = {letter_fifth, letter_fourth, letter_third, letter_second, letter_first};
        want.len     = word_length;
        want.letters = seen;
        want.rank    = expected_rank(word_length, seen);
        rank_q.push_back(want);
      end
      if (drained && !leftovers_done) begin
        foreach (rank_q[i])
          report_mismatch($sformatf("no rank returned for len %0d word, want %0d",
                                    rank_q[i].len, rank_q[i].rank));
        leftovers_done = 1'b1;
      end
    end
    pending <= rank_q.size();
  end

endmodule

@@ bench/tb_increasing_word_rank.sv @@
`timescale 1ns / 1ps
// Testbench top for increasing_word_rank: drives directed and random words with
// random gaps and result stalls; iwr_rank_checker does the prediction.
// Depends on iwr_pkg, increasing_word_rank and iwr_rank_checker.
module tb_increasing_word_rank;

  typedef logic [iwr_pkg::MAX_LETTERS-1:0][iwr_pkg::LETTER_W-1:0] word_t;

  localparam int QUIET_LIMIT = 1000;
  localparam int RANDOM_WORDS = 900;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [iwr_pkg::LEN_W-1:0]    word_length = '0;
  logic [iwr_pkg::LETTER_W-1:0] letter_first = '0;
  logic [iwr_pkg::LETTER_W-1:0] letter_second = '0;
  logic [iwr_pkg::LETTER_W-1:0] letter_third = '0;
  logic [iwr_pkg::LETTER_W-1:0] letter_fourth = '0;
  logic [iwr_pkg::LETTER_W-1:0] letter_fifth = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [iwr_pkg::RANK_W-1:0]   word_rank;
  logic                         drained = 1'b0;

  int pending;
  int fail_total;
  int checked;
  int zero_ranks;
  int sent = 0;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  increasing_word_rank dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .word_length   (word_length),
    .letter_first  (letter_first),
    .letter_second (letter_second),
    .letter_third  (letter_third),
    .letter_fourth (letter_fourth),
    .letter_fifth  (letter_fifth),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .word_rank     (word_rank)
  );

  iwr_rank_checker u_rank_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .word_length   (word_length),
    .letter_first  (letter_first),
    .letter_second (letter_second),
    .letter_third  (letter_third),
    .letter_fourth (letter_fourth),
    .letter_fifth  (letter_fifth),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .word_rank     (word_rank),
    .drained       (drained),
    .pending       (pending),
    .fail_total    (fail_total),
    .checked       (checked),
    .zero_ranks    (zero_ranks)
  );

  function automatic word_t spell(input int a, input int b, input int c,
                                  input int d, input int e);
    word_t w;
    w[0] = iwr_pkg::letter_t'(a);
    w[1] = iwr_pkg::letter_t'(b);
    w[2] = iwr_pkg::letter_t'(c);
    w[3] = iwr_pkg::letter_t'(d);
    w[4] = iwr_pkg::letter_t'(e);
    return w;
  endfunction

  // distinct letters in ascending order; unused places hold any code
  function automatic word_t increasing_word(input int len);
    logic [25:0] picked;
    word_t       w;
    int          count;
    int          x;
    int          k;
    picked = '0;
    count  = 0;
    while (count < len) begin
      x = $urandom_range(0, 25);
      if (!picked[x]) begin
        picked[x] = 1'b1;
        count++;
      end
    end
    for (k = 0; k < iwr_pkg::MAX_LETTERS; k++)
      w[k] = iwr_pkg::letter_t'($urandom_range(0, 31));
    k = 0;
    for (x = 0; x < 26; x++)
      if (picked[x]) begin
        w[k] = iwr_pkg::letter_t'(x);
        k++;
      end
    return w;
  endfunction

  task automatic apply_word(input iwr_pkg::len_t len, input word_t w);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    word_length   <= len;
    letter_first  <= w[0];
    letter_second <= w[1];
    letter_third  <= w[2];
    letter_fourth <= w[3];
    letter_fifth  <= w[4];
    in_valid      <= 1'b1;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic wait_drained;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    word_t            w;
    int               len;
    int               p;
    int               pick;
    iwr_pkg::letter_t hold;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // corners: first and last words of each length, bad lengths, bad letters
    apply_word(3'd1, spell(0, 0, 0, 0, 0));
    apply_word(3'd1, spell(25, 0, 0, 0, 0));
    apply_word(3'd2, spell(0, 1, 0, 0, 0));
    apply_word(3'd2, spell(24, 25, 0, 0, 0));
    apply_word(3'd3, spell(0, 1, 2, 0, 0));
    apply_word(3'd3, spell(23, 24, 25, 0, 0));
    apply_word(3'd4, spell(0, 1, 2, 3, 0));
    apply_word(3'd4, spell(22, 23, 24, 25, 0));
    apply_word(3'd5, spell(0, 1, 2, 3, 4));
    apply_word(3'd5, spell(21, 22, 23, 24, 25));
    apply_word(3'd5, spell(0, 7, 13, 19, 25));
    apply_word(3'd0, spell(0, 1, 2, 3, 4));
    apply_word(3'd6, spell(0, 1, 2, 3, 4));
    apply_word(3'd7, spell(1, 2, 3, 4, 5));
    apply_word(3'd1, spell(31, 0, 0, 0, 0));
    apply_word(3'd1, spell(26, 0, 0, 0, 0));
    apply_word(3'd3, spell(2, 9, 26, 0, 0));
    apply_word(3'd4, spell(1, 2, 30, 31, 0));
    apply_word(3'd2, spell(5, 5, 0, 0, 0));
    apply_word(3'd3, spell(1, 4, 3, 0, 0));
    apply_word(3'd5, spell(25, 24, 23, 22, 21));
    // letters past the length must not matter
    apply_word(3'd1, spell(7, 31, 31, 31, 31));
    apply_word(3'd2, spell(3, 10, 0, 31, 17));
    apply_word(3'd4, spell(4, 9, 18, 25, 2));

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 50 == 0) tx_calm = ($urandom_range(0, 3) == 0);
      if (i == RANDOM_WORDS / 2) wait_drained();
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        len = $urandom_range(1, iwr_pkg::MAX_LETTERS);
        w   = increasing_word(len);
      end else if (pick < 90) begin
        len = $urandom_range(2, iwr_pkg::MAX_LETTERS);
        w   = increasing_word(len);
        p   = $urandom_range(0, len - 2);
        case ($urandom_range(0, 2))
          0: w[p+1] = w[p];
          1: begin
            hold   = w[p];
            w[p]   = w[p+1];
            w[p+1] = hold;
          end
          default: w[$urandom_range(0, len - 1)] = iwr_pkg::letter_t'($urandom_range(26, 31));
        endcase
      end else begin
        len = $urandom_range(0, 7);
        w   = spell($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31),
                    $urandom_range(0, 31), $urandom_range(0, 31));
      end
      apply_word(iwr_pkg::len_t'(len), w);
    end

    wait_drained();
    // catch any stray result
    repeat (40) @(posedge clk);
    drained <= 1'b1;
    repeat (2) @(posedge clk);
    $display("covered %0d words incl. bad lengths, bad letters and unordered words",
             sent);
    $display("%0d ranks compared, %0d of them zero", checked, zero_ranks);
    if (fail_total == 0)
      $display("tb_increasing_word_rank: clean");
    else
      $display("tb_increasing_word_rank: errors");
    $finish;
  end

  // result side: hold stall for a random stretch before each transfer
  initial begin : result_side
    int hold_cycles;
    int taken;
    taken = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      hold_cycles = rx_calm ? 0 : $urandom_range(0, 14);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (hold_cycles) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      taken++;
      if (taken % 40 == 0) rx_calm = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb_increasing_word_rank: errors");
    $finish;
  end

endmodule
